/* hw/rtl/repeating_timer_table_defines.svh */
// assertion macros for the timer table checker
`ifndef REPEATING_TIMER_TABLE_DEFINES_SVH
`define REPEATING_TIMER_TABLE_DEFINES_SVH
// implication checked every clock, quiet during reset
`define RTT_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("rtt check failed");
// next-cycle implication, quiet during reset
`define RTT_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("rtt check failed");
`endif

/* hw/rtl/rtt_pkg.sv */
// shared types and codes for the repeating timer table
`timescale 1ns / 1ps
package rtt_pkg;
   localparam logic [2:0] ACT_TICK = 3'd0;
   localparam logic [2:0] ACT_SCHEDULE = 3'd1;
   localparam logic [2:0] ACT_CLEAR = 3'd2;
   localparam logic [2:0] ACT_SHIFT = 3'd3;
   localparam logic [2:0] ACT_DROP = 3'd4;

   localparam logic [2:0] KIND_SCHEDULED = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_FIRED = 3'd2;
   localparam logic [2:0] KIND_TICK_DONE = 3'd3;
   localparam logic [2:0] KIND_ACTION_DONE = 3'd4;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_NULL_CB = 3'd1;
   localparam logic [2:0] ERR_BAD_COUNT = 3'd2;
   localparam logic [2:0] ERR_BAD_INTERVAL = 3'd3;
   localparam logic [2:0] ERR_FULL = 3'd4;

   localparam logic [15:0] COUNT_FOREVER = 16'hFFFF;

   typedef struct packed {
      logic [2:0] action;
      logic [31:0] now_time;
      logic signed [31:0] interval;
      logic signed [15:0] repeat_count;
      logic [15:0] callback_id;
      logic [7:0] owner_id;
      logic [3:0] handle_slot;
      logic [15:0] handle_tag;
      logic signed [31:0] shift_amount;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] slot;
      logic [15:0] tag;
      logic [15:0] fired_callback;
      logic [7:0] fired_owner;
      logic [2:0] error_code;
      logic last;
   } rsp_type;
endpackage

/* hw/rtl/repeating_timer_table.sv */
// repeating timer table: slot store with a sequencer that walks slots one per cycle
//
//  channel | ports                       | transfer
//  req     | start, busy, req_data       | start high while busy low
//  rsp     | rsp_valid, rsp_data         | each result valid for a single cycle, no stall
//
// tick, shift and drop keep busy high while one shared compare/add unit visits every
// slot, one slot per cycle. schedule walks all slots for the free-slot search; clear and
// unknown actions skip the walk. results are registered, so the final result shows in
// the same cycle that busy falls. reset clears valid bits, time and tag counter at once.
// the receiver cannot stall, so results leave as produced.
`timescale 1ns / 1ps
module repeating_timer_table #(
   parameter int SLOTS = 16,
   parameter int TIME_BITS = 32
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input rtt_pkg::req_type req_data,
   output logic rsp_valid,
   output rtt_pkg::rsp_type rsp_data
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   rtt_pkg::req_type req_ff;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0] cur_time_ff, cur_time_in;
   logic [15:0] next_tag_ff, next_tag_in;
   logic found_ff, found_in;
   logic [IW-1:0] free_ff, free_in;
   logic rsp_valid_ff, rsp_valid_in;
   rtt_pkg::rsp_type rsp_ff, rsp_in;

   logic [TIME_BITS-1:0] expiry_mem [SLOTS];
   logic [30:0] period_mem [SLOTS];
   logic [15:0] remain_mem [SLOTS];
   logic [15:0] cb_mem [SLOTS];
   logic [7:0] owner_mem [SLOTS];
   logic [15:0] tag_mem [SLOTS];

   logic [IW-1:0] idx;
   logic [IW-1:0] hslot;
   logic hslot_ok;
   logic [TIME_BITS:0] add_sum;
   logic [TIME_BITS-1:0] add_a, add_b, add_res, sub_res;
   logic [TIME_BITS:0] sub_diff;
   logic [TIME_BITS-1:0] now_t;
   logic [31:0] mag;
   logic neg;
   logic [15:0] rem_dec;
   logic we_exp, we_rem, we_new;
   logic [TIME_BITS-1:0] exp_wd;
   logic [IW-1:0] wr_idx;
   logic [2:0] sched_err;

   assign idx = idx_ff[IW-1:0];
   assign hslot = IW >= 4 ? IW'(req_ff.handle_slot) : req_ff.handle_slot[IW-1:0];
   assign hslot_ok = {28'd0, req_ff.handle_slot} < SLOTS;
   assign now_t = TIME_BITS'(req_ff.now_time);
   assign neg = req_ff.shift_amount[31];
   assign mag = neg ? (~req_ff.shift_amount + 32'd1) : req_ff.shift_amount;

   // shared saturating adder
   always_comb begin
      add_a = expiry_mem[idx];
      add_b = '0;
      if (req_ff.action == rtt_pkg::ACT_SHIFT) begin
         add_b = TIME_BITS'({1'b0, mag});
      end else if (req_ff.action == rtt_pkg::ACT_SCHEDULE) begin
         add_a = cur_time_ff;
         add_b = TIME_BITS'({1'b0, req_ff.interval[30:0]});
      end else begin
         add_b = TIME_BITS'({1'b0, period_mem[idx]});
      end
      if (TIME_BITS < 33 && req_ff.action == rtt_pkg::ACT_SHIFT
          && (TIME_BITS < 32 && (mag >> TIME_BITS) != 32'd0)) begin
         add_sum = {1'b1, TMAX};
      end else begin
         add_sum = {1'b0, add_a} + {1'b0, add_b};
      end
      add_res = add_sum[TIME_BITS] ? TMAX : add_sum[TIME_BITS-1:0];
      sub_diff = {1'b0, expiry_mem[idx]} - {1'b0, add_b};
      sub_res = sub_diff[TIME_BITS] ? '0 : sub_diff[TIME_BITS-1:0];
      if (TIME_BITS < 32 && (mag >> TIME_BITS) != 32'd0) sub_res = '0;
   end

   assign rem_dec = (remain_mem[idx] == rtt_pkg::COUNT_FOREVER) ? remain_mem[idx]
                  : remain_mem[idx] - 16'd1;

   // argument checks for schedule
   always_comb begin
      sched_err = rtt_pkg::ERR_NONE;
      if (req_ff.callback_id == 16'd0) sched_err = rtt_pkg::ERR_NULL_CB;
      else if (req_ff.repeat_count == 16'sd0 || (req_ff.repeat_count[15]
               && req_ff.repeat_count != -16'sd1)) sched_err = rtt_pkg::ERR_BAD_COUNT;
      else if (req_ff.interval[31]) sched_err = rtt_pkg::ERR_BAD_INTERVAL;
      else if (!found_ff) sched_err = rtt_pkg::ERR_FULL;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      cur_time_in = cur_time_ff;
      next_tag_in = next_tag_ff;
      found_in = found_ff;
      free_in = free_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      we_exp = 1'b0;
      we_rem = 1'b0;
      we_new = 1'b0;
      exp_wd = add_res;
      wr_idx = idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               idx_in = '0;
               found_in = 1'b0;
               free_in = '0;
            end
         end
         ST_SCAN: begin
            if (idx_ff == CW'(SLOTS) || req_ff.action == rtt_pkg::ACT_CLEAR
                || req_ff.action > rtt_pkg::ACT_DROP) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + CW'(1);
               if (req_ff.action == rtt_pkg::ACT_TICK) begin
                  cur_time_in = now_t;
                  if (valid_ff[idx] && expiry_mem[idx] <= now_t) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind = rtt_pkg::KIND_FIRED;
                     rsp_in.slot = 4'(idx);
                     rsp_in.tag = tag_mem[idx];
                     rsp_in.fired_callback = cb_mem[idx];
                     rsp_in.fired_owner = owner_mem[idx];
                     we_rem = 1'b1;
                     if (rem_dec == 16'd0) valid_in[idx] = 1'b0;
                     else we_exp = 1'b1;
                  end
               end else if (req_ff.action == rtt_pkg::ACT_SHIFT) begin
                  if (valid_ff[idx]) begin
                     we_exp = 1'b1;
                     exp_wd = neg ? sub_res : add_res;
                  end
               end else if (req_ff.action == rtt_pkg::ACT_DROP) begin
                  if (valid_ff[idx] && owner_mem[idx] == req_ff.owner_id)
                     valid_in[idx] = 1'b0;
               end else if (req_ff.action == rtt_pkg::ACT_SCHEDULE) begin
                  if (!valid_ff[idx] && !found_ff) begin
                     found_in = 1'b1;
                     free_in = idx;
                  end
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.last = 1'b1;
            rsp_in.kind = rtt_pkg::KIND_ACTION_DONE;
            if (req_ff.action == rtt_pkg::ACT_TICK) begin
               rsp_in.kind = rtt_pkg::KIND_TICK_DONE;
            end else if (req_ff.action == rtt_pkg::ACT_SCHEDULE) begin
               if (sched_err != rtt_pkg::ERR_NONE) begin
                  rsp_in.kind = rtt_pkg::KIND_REJECTED;
                  rsp_in.error_code = sched_err;
               end else begin
                  rsp_in.kind = rtt_pkg::KIND_SCHEDULED;
                  rsp_in.slot = 4'(free_ff);
                  rsp_in.tag = next_tag_ff;
                  wr_idx = free_ff;
                  we_new = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  next_tag_in = next_tag_ff + 16'd1;
               end
            end else if (req_ff.action == rtt_pkg::ACT_CLEAR) begin
               if (hslot_ok && valid_ff[hslot] && tag_mem[hslot] == req_ff.handle_tag)
                  valid_in[hslot] = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         cur_time_ff <= '0;
         next_tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cur_time_ff <= cur_time_in;
         next_tag_ff <= next_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and slot store
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      found_ff <= found_in;
      free_ff <= free_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && start) req_ff <= req_data;
      if (we_exp) expiry_mem[wr_idx] <= exp_wd;
      if (we_rem) remain_mem[wr_idx] <= rem_dec;
      if (we_new) begin
         expiry_mem[wr_idx] <= add_res;
         period_mem[wr_idx] <= req_ff.interval[30:0];
         remain_mem[wr_idx] <= req_ff.repeat_count;
         cb_mem[wr_idx] <= req_ff.callback_id;
         owner_mem[wr_idx] <= req_ff.owner_id;
         tag_mem[wr_idx] <= next_tag_ff;
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

/* hw/rtl/rtt_checker.sv */
// port-level checks for the repeating timer table
`timescale 1ns / 1ps
`include "repeating_timer_table_defines.svh"
module rtt_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input rtt_pkg::rsp_type rsp_data,
   input logic rsp_valid
);
   // an accepted request makes the block busy
   `RTT_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   // the final result shows once the block is free
   `RTT_ASSERT_IMP(a_last_free, clock, reset, rsp_valid && rsp_data.last, !busy)
   // fired results are never the final one
   `RTT_ASSERT_IMP(a_fire_not_last, clock, reset,
      rsp_valid && rsp_data.kind == rtt_pkg::KIND_FIRED, !rsp_data.last)
   // an error code only comes with a rejection
   `RTT_ASSERT_IMP(a_err_kind, clock, reset,
      rsp_valid && rsp_data.error_code != rtt_pkg::ERR_NONE,
      rsp_data.kind == rtt_pkg::KIND_REJECTED)
endmodule

bind repeating_timer_table rtt_checker u_rtt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_data(rsp_data), .rsp_valid(rsp_valid)
);
